@@ src/mrtu_pkg.sv @@
// Shared types, status codes and the CRC-16 byte step for the Modbus RTU slave engine.
// No dependencies.
`timescale 1ns / 1ps

package mrtu_pkg;

  typedef struct packed {
    logic              opcode;
    logic [7:0]        rx_byte;
    logic signed [7:0] temperature;
    logic [6:0]        humidity;
    logic              sensor_ok;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] tx_byte;
    logic       last;
  } out_t;

  // opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // status codes
  localparam logic [2:0] ST_REPLY     = 3'd0;
  localparam logic [2:0] ST_ADDR_ERR  = 3'd1;
  localparam logic [2:0] ST_FUNC_ERR  = 3'd2;
  localparam logic [2:0] ST_CRC_ERR   = 3'd3;
  localparam logic [2:0] ST_TIMEOUT   = 3'd4;
  localparam logic [2:0] ST_SENSOR    = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] CFG_FUNCTION   = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT    = 2'd2;

  localparam logic [7:0] RST_SLAVE_ADDR = 8'h01;
  localparam logic [7:0] RST_FUNCTION   = 8'h03;
  localparam logic [7:0] RST_TIMEOUT    = 8'd10;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] REPLY_BYTE_COUNT = 8'd4;
  localparam logic [8:0] IDLE_MAX         = 9'd511;

  // Reflected CRC-16: fold in one byte, eight shift steps.
  function automatic logic [15:0] crc_feed(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ src/modbus_rtu_slave_frame_engine.sv @@
// Modbus RTU slave frame engine: request buffer memory, frame checker, reply serializer.
// Depends on mrtu_pkg.
`timescale 1ns / 1ps
// A tick timeout status shows the next cycle. A complete frame passes S_CHK0, S_CHK1, S_CHK2
// (registered memory reads, one per state); S_CHK2 loads an error status once the output is
// free, or S_REPLY streams 9 beats, 1/cycle while out_ready holds. Input takes one item per
// cycle while frames fill (a timing-out tick needs a free output); it stalls in check and reply.
// Reset (rst_n low, synchronous): config to defaults, byte and idle counts cleared,
// output empty. The request memory is not cleared; entries are always written before read.

module modbus_rtu_slave_frame_engine (
  input  logic               clk,
  input  logic               rst_n,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  mrtu_pkg::in_t      in_data,
  // results
  output logic               out_valid,
  input  logic               out_ready,
  output mrtu_pkg::out_t     out_data,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  typedef enum logic [2:0] {
    S_RUN,    // collecting bytes and ticks
    S_CHK0,   // memory returns byte 0: address check
    S_CHK1,   // memory returns byte 1: function check
    S_CHK2,   // memory returns byte 6: CRC check and verdict
    S_REPLY   // streaming reply beats
  } state_t;

  state_t state_r;

  // config
  logic [7:0] slave_addr_r;
  logic [7:0] func_r;
  logic [7:0] timeout_r;

  // frame state
  logic [3:0]  byte_count_r;
  logic [8:0]  idle_r;
  logic [15:0] crc_r;        // request CRC while filling, reply CRC while streaming
  logic [7:0]  b7_r;         // last request byte, kept out of memory
  logic signed [7:0] temp_r;
  logic [6:0]  hum_r;
  logic        ok_r;
  logic        addr_ok_r;
  logic        func_ok_r;
  logic [3:0]  reply_idx_r;

  // output register
  logic           out_valid_r;
  mrtu_pkg::out_t out_data_r;

  // request buffer memory: one write port, one registered read port
  logic [7:0] req_mem [8];
  logic [7:0] rd_data_r;
  logic [2:0] rd_addr;
  logic       mem_we;

  logic       out_free;
  logic       in_fire;
  logic [8:0] idle_inc;
  logic       tick_timeout;
  logic [7:0] reply_byte;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign out_free = !out_valid_r || out_ready;

  assign idle_inc = (idle_r == mrtu_pkg::IDLE_MAX) ? idle_r : idle_r + 9'd1;
  assign tick_timeout = (in_data.opcode == mrtu_pkg::OP_TICK) && (byte_count_r != 4'd0) &&
                        (idle_inc > {1'b0, timeout_r});

  // Only a timing-out tick needs the output slot; in S_RUN everything else goes in freely.
  assign in_ready = (state_r == S_RUN) && (out_free || !tick_timeout);
  assign in_fire  = in_valid && in_ready;

  assign mem_we = in_fire && (in_data.opcode == mrtu_pkg::OP_BYTE) &&
                  (byte_count_r[2:0] != 3'd7);

  // Address 0 is read while idle so it is ready the cycle after the final byte.
  always_comb begin
    unique case (state_r)
      S_RUN:   rd_addr = 3'd0;
      S_CHK0:  rd_addr = 3'd1;
      default: rd_addr = 3'd6;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      req_mem[byte_count_r[2:0]] <= in_data.rx_byte;
    end
    rd_data_r <= req_mem[rd_addr];
  end

  // reply byte for the current beat
  always_comb begin
    unique case (reply_idx_r)
      4'd0:    reply_byte = slave_addr_r;
      4'd1:    reply_byte = func_r;
      4'd2:    reply_byte = mrtu_pkg::REPLY_BYTE_COUNT;
      4'd3:    reply_byte = {8{temp_r[7]}};
      4'd4:    reply_byte = temp_r;
      4'd5:    reply_byte = 8'h00;
      4'd6:    reply_byte = {1'b0, hum_r};
      4'd7:    reply_byte = crc_r[7:0];
      4'd8:    reply_byte = crc_r[15:8];
      default: reply_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_RUN;
      slave_addr_r <= mrtu_pkg::RST_SLAVE_ADDR;
      func_r       <= mrtu_pkg::RST_FUNCTION;
      timeout_r    <= mrtu_pkg::RST_TIMEOUT;
      byte_count_r <= 4'd0;
      idle_r       <= 9'd0;
      reply_idx_r  <= 4'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          mrtu_pkg::CFG_SLAVE_ADDR: slave_addr_r <= cfg_data;
          mrtu_pkg::CFG_FUNCTION:   func_r       <= cfg_data;
          mrtu_pkg::CFG_TIMEOUT:    timeout_r    <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_RUN: begin
          if (in_fire) begin
            if (in_data.opcode == mrtu_pkg::OP_TICK) begin
              if (byte_count_r != 4'd0) begin
                if (tick_timeout) begin
                  byte_count_r <= 4'd0;
                  idle_r       <= 9'd0;
                  out_valid_r  <= 1'b1;
                  out_data_r   <= '{status: mrtu_pkg::ST_TIMEOUT, tx_byte: 8'h00, last: 1'b1};
                end else begin
                  idle_r <= idle_inc;
                end
              end
            end else begin
              idle_r <= 9'd0;
              if (byte_count_r == 4'd0) begin
                crc_r <= mrtu_pkg::crc_feed(mrtu_pkg::CRC_INIT, in_data.rx_byte);
              end else if (byte_count_r < 4'd6) begin
                crc_r <= mrtu_pkg::crc_feed(crc_r, in_data.rx_byte);
              end
              if (byte_count_r[2:0] == 3'd7) begin
                byte_count_r <= 4'd0;
                b7_r         <= in_data.rx_byte;
                temp_r       <= in_data.temperature;
                hum_r        <= in_data.humidity;
                ok_r         <= in_data.sensor_ok;
                state_r      <= S_CHK0;
              end else begin
                byte_count_r <= byte_count_r + 4'd1;
              end
            end
          end
        end
        S_CHK0: begin
          addr_ok_r <= (rd_data_r == slave_addr_r);
          state_r   <= S_CHK1;
        end
        S_CHK1: begin
          func_ok_r <= (rd_data_r == func_r);
          state_r   <= S_CHK2;
        end
        S_CHK2: begin
          // checks in order: address, function, CRC, sensor
          if (!addr_ok_r || !func_ok_r || (rd_data_r != crc_r[7:0]) ||
              (b7_r != crc_r[15:8]) || !ok_r) begin
            if (out_free) begin
              out_valid_r <= 1'b1;
              out_data_r.tx_byte <= 8'h00;
              out_data_r.last    <= 1'b1;
              priority if (!addr_ok_r) begin
                out_data_r.status <= mrtu_pkg::ST_ADDR_ERR;
              end else if (!func_ok_r) begin
                out_data_r.status <= mrtu_pkg::ST_FUNC_ERR;
              end else if ((rd_data_r != crc_r[7:0]) || (b7_r != crc_r[15:8])) begin
                out_data_r.status <= mrtu_pkg::ST_CRC_ERR;
              end else begin
                out_data_r.status <= mrtu_pkg::ST_SENSOR;
              end
              state_r <= S_RUN;
            end
          end else begin
            reply_idx_r <= 4'd0;
            state_r     <= S_REPLY;
          end
        end
        S_REPLY: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '{status: mrtu_pkg::ST_REPLY, tx_byte: reply_byte,
                             last: (reply_idx_r == 4'd8)};
            // reply CRC accumulates over the first seven beats
            if (reply_idx_r == 4'd0) begin
              crc_r <= mrtu_pkg::crc_feed(mrtu_pkg::CRC_INIT, reply_byte);
            end else if (reply_idx_r < 4'd7) begin
              crc_r <= mrtu_pkg::crc_feed(crc_r, reply_byte);
            end
            if (reply_idx_r == 4'd8) begin
              state_r <= S_RUN;
            end else begin
              reply_idx_r <= reply_idx_r + 4'd1;
            end
          end
        end
        default: state_r <= S_RUN;
      endcase
    end
  end

endmodule

@@ src/mrtu_checker.sv @@
// Port-level checks for the Modbus RTU slave engine, bound to the top level.
// Depends on mrtu_pkg and modbus_rtu_slave_frame_engine.
`timescale 1ns / 1ps

module mrtu_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input mrtu_pkg::out_t out_data
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // status beats are single, final and carry no byte
  a_status_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != mrtu_pkg::ST_REPLY) |->
      out_data.last && (out_data.tx_byte == 8'h00))
    else $error("status beat malformed");

  // status codes stay in range
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status <= mrtu_pkg::ST_SENSOR))
    else $error("status code out of range");

  // a reply continues without gaps and blocks input until its final beat is loaded
  a_reply_streams: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_data.status == mrtu_pkg::ST_REPLY) && !out_data.last |=>
      out_valid && (out_data.status == mrtu_pkg::ST_REPLY) && (out_data.last || !in_ready))
    else $error("reply stream broken");

endmodule

bind modbus_rtu_slave_frame_engine mrtu_checker u_mrtu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ tb/tb.sv @@
// Self-checking testbench for modbus_rtu_slave_frame_engine: drives bytes and ticks,
// predicts replies and status beats in-line, checks every result beat.
// Depends on mrtu_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 11;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 20;
  localparam int RANDOM_ITEMS    = 180;
  localparam int PHASE_ITEMS     = 60;
  localparam int FRAME_BYTES     = 8;
  localparam int REPLY_BYTES     = 9;

  // what a random request looks like on the wire
  typedef enum {
    FR_GOOD,
    FR_ADDR_BAD,
    FR_FUNC_BAD,
    FR_CRC_BAD,
    FR_NOISE,
    FR_TIMEOUT
  } frame_kind_t;

  // ready patterns of the result sink
  typedef enum {
    SINK_OPEN,
    SINK_COIN,
    SINK_PERIODIC,
    SINK_SPARSE
  } sink_mode_t;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  mrtu_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  mrtu_pkg::out_t out_data;
  logic           cfg_valid;
  logic           cfg_ready;
  logic [1:0]     cfg_index;
  logic [7:0]     cfg_data;

  modbus_rtu_slave_frame_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a copy of the engine's registers and frame buffer,
  // updated on every accepted input beat and config write.
  // ---------------------------------------------------------------------------
  logic [7:0] exp_addr;
  logic [7:0] exp_func;
  logic [7:0] exp_tmo;
  logic [7:0] frame_buf [FRAME_BYTES];
  int         frame_fill;
  int         idle_ticks;

  mrtu_pkg::out_t reply_q [$];     // result beats still owed by the engine

  int         errors       = 0;
  int         active_items = 0; // items the engine acts on (not ignored ticks)
  int         cycle_count  = 0;
  int         burst_left   = 0;
  bit         steady_send  = 1'b0;
  bit         hold_off_req = 1'b0;

  logic [7:0] req_bytes [FRAME_BYTES]; // request under construction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin : clock_gen
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Run limit; a hang anywhere ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // CRC-16, reflected, bit-serial form: data bit enters at the lsb feedback.
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ b[i];
      acc = acc >> 1;
      if (fb) begin
        acc = acc ^ mrtu_pkg::CRC_POLY;
      end
    end
    return acc;
  endfunction

  function automatic void push_status(input logic [2:0] code);
    mrtu_pkg::out_t r;
    r.status  = code;
    r.tx_byte = 8'h00;
    r.last    = 1'b1;
    reply_q.push_back(r);
  endfunction

  // Expected result beats for one accepted input beat.
  function automatic void predict_replies(input mrtu_pkg::in_t it);
    logic [15:0]    crc;
    logic [7:0]     reply [REPLY_BYTES];
    mrtu_pkg::out_t r;
    if (it.opcode == mrtu_pkg::OP_TICK) begin
      // ticks only matter inside a partial frame
      if (frame_fill == 0) begin
        return;
      end
      active_items++;
      if (idle_ticks < mrtu_pkg::IDLE_MAX) begin
        idle_ticks++;
      end
      if (idle_ticks > exp_tmo) begin
        frame_fill = 0;
        idle_ticks = 0;
        push_status(mrtu_pkg::ST_TIMEOUT);
      end
      return;
    end

    active_items++;
    frame_buf[frame_fill] = it.rx_byte;
    frame_fill++;
    idle_ticks = 0;
    if (frame_fill < FRAME_BYTES) begin
      return;
    end
    frame_fill = 0;

    // checks in priority order: address, function, crc, sensor
    if (frame_buf[0] != exp_addr) begin
      push_status(mrtu_pkg::ST_ADDR_ERR);
      return;
    end
    if (frame_buf[1] != exp_func) begin
      push_status(mrtu_pkg::ST_FUNC_ERR);
      return;
    end
    crc = mrtu_pkg::CRC_INIT;
    for (int k = 0; k < FRAME_BYTES - 2; k++) begin
      crc = crc16_step(crc, frame_buf[k]);
    end
    if ({frame_buf[7], frame_buf[6]} != crc) begin
      push_status(mrtu_pkg::ST_CRC_ERR);
      return;
    end
    if (!it.sensor_ok) begin
      push_status(mrtu_pkg::ST_SENSOR);
      return;
    end

    reply[0] = exp_addr;
    reply[1] = exp_func;
    reply[2] = mrtu_pkg::REPLY_BYTE_COUNT;
    reply[3] = {8{it.temperature[7]}};   // sign extension of the reading
    reply[4] = it.temperature;
    reply[5] = 8'h00;
    reply[6] = {1'b0, it.humidity};
    crc = mrtu_pkg::CRC_INIT;
    for (int k = 0; k < REPLY_BYTES - 2; k++) begin
      crc = crc16_step(crc, reply[k]);
    end
    reply[7] = crc[7:0];
    reply[8] = crc[15:8];
    for (int k = 0; k < REPLY_BYTES; k++) begin
      r.status  = mrtu_pkg::ST_REPLY;
      r.tx_byte = reply[k];
      r.last    = (k == REPLY_BYTES - 1);
      reply_q.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result beat against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    mrtu_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual %0d/%02h/%0b",
                 $time, out_data.status, out_data.tx_byte, out_data.last);
        errors++;
      end else begin
        want = reply_q.pop_front();
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_data.status);
          errors++;
        end
        if (out_data.tx_byte !== want.tx_byte) begin
          $display("%0t: tx_byte expected %02h actual %02h", $time, want.tx_byte,
                   out_data.tx_byte);
          errors++;
        end
        if (out_data.last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_data.last);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: out_ready follows a pattern picked at random for a phase of random
  // length. A hold-off request parks it low for HOLD_OFF_CYCLES.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    sink_mode_t mode;
    int         phase_cnt;
    out_ready = 1'b0;
    mode      = SINK_OPEN;
    phase_cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      if (phase_cnt == 0) begin
        mode      = sink_mode_t'($urandom_range(0, 3));
        phase_cnt = $urandom_range(16, 80);
      end
      phase_cnt--;
      unique case (mode)
        SINK_OPEN:     out_ready <= 1'b1;
        SINK_COIN:     out_ready <= 1'($urandom_range(0, 1));
        SINK_PERIODIC: out_ready <= (phase_cnt % 4) != 0;
        default:       out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Sensor fields mostly within the sensor's range, now and then any bit pattern.
  function automatic mrtu_pkg::in_t rand_sensor_item(input logic op, input logic [7:0] b);
    mrtu_pkg::in_t it;
    it.opcode = op;
    it.rx_byte = b;
    if ($urandom_range(0, 9) == 0) begin
      it.temperature = 8'($urandom_range(0, 255));
      it.humidity    = 7'($urandom_range(0, 127));
    end else begin
      it.temperature = 8'($urandom_range(0, 120) - 40);
      it.humidity    = 7'($urandom_range(0, 100));
    end
    it.sensor_ok = ($urandom_range(0, 5) != 0);
    return it;
  endfunction

  // One input beat. Sender works in bursts with gaps unless steady_send is set.
  // Entered and left just after a falling edge; valid is held across beats.
  task automatic send_item(input mrtu_pkg::in_t it);
    int gap;
    if (!steady_send && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predict_replies(it);
    @(negedge clk);
  endtask

  task automatic send_tick();
    send_item(rand_sensor_item(mrtu_pkg::OP_TICK, 8'($urandom_range(0, 255))));
  endtask

  // Fill req_bytes: address, function, four body bytes, crc (optionally damaged).
  function automatic void build_request(input logic [7:0] addr, input logic [7:0] func,
                                        input logic [15:0] crc_flip, input logic [31:0] body);
    logic [15:0] crc;
    req_bytes[0] = addr;
    req_bytes[1] = func;
    for (int k = 0; k < 4; k++) begin
      req_bytes[2 + k] = body[8 * k +: 8];
    end
    crc = mrtu_pkg::CRC_INIT;
    for (int k = 0; k < FRAME_BYTES - 2; k++) begin
      crc = crc16_step(crc, req_bytes[k]);
    end
    crc = crc ^ crc_flip;
    req_bytes[6] = crc[7:0];
    req_bytes[7] = crc[15:8];
  endfunction

  // Send the first n bytes of req_bytes. The eighth byte carries fin's sensor
  // fields. Optional ticks between bytes stay within the timeout.
  task automatic send_request(input int n, input mrtu_pkg::in_t fin, input bit with_ticks);
    mrtu_pkg::in_t it;
    for (int k = 0; k < n; k++) begin
      if (with_ticks && exp_tmo > 0 && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, (exp_tmo > 3) ? 3 : exp_tmo)) send_tick();
      end
      if (k == FRAME_BYTES - 1) begin
        it = fin;
        it.opcode  = mrtu_pkg::OP_BYTE;
        it.rx_byte = req_bytes[k];
      end else begin
        it = rand_sensor_item(mrtu_pkg::OP_BYTE, req_bytes[k]);
      end
      send_item(it);
    end
  endtask

  // Drop valid and wait for every owed beat, then let the engine settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (reply_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all three registers, one beat each; only called with the engine idle.
  task automatic write_regs(input logic [7:0] addr, input logic [7:0] func,
                            input logic [7:0] tmo);
    logic [7:0] vals [3];
    logic [1:0] idx  [3];
    vals = '{addr, func, tmo};
    idx  = '{mrtu_pkg::CFG_SLAVE_ADDR, mrtu_pkg::CFG_FUNCTION, mrtu_pkg::CFG_TIMEOUT};
    for (int r = 0; r < 3; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[r];
      cfg_data  <= vals[r];
      do @(posedge clk); while (!cfg_ready);
      unique case (idx[r])
        mrtu_pkg::CFG_SLAVE_ADDR: exp_addr = vals[r];
        mrtu_pkg::CFG_FUNCTION:   exp_func = vals[r];
        default:                  exp_tmo  = vals[r];
      endcase
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // One request of a random kind with random content.
  task automatic send_random_frame();
    frame_kind_t   kind;
    mrtu_pkg::in_t fin;
    int            pick;
    int            n;
    pick = $urandom_range(0, 99);
    if (pick < 55)      kind = FR_GOOD;
    else if (pick < 63) kind = FR_ADDR_BAD;
    else if (pick < 71) kind = FR_FUNC_BAD;
    else if (pick < 81) kind = FR_CRC_BAD;
    else if (pick < 90) kind = FR_NOISE;
    else                kind = FR_TIMEOUT;
    // long timeouts cost hundreds of ticks; send noise instead when the timeout exceeds 12
    if (kind == FR_TIMEOUT && exp_tmo > 12) begin
      kind = FR_NOISE;
    end
    fin = rand_sensor_item(mrtu_pkg::OP_BYTE, 8'h00);
    steady_send = ($urandom_range(0, 4) == 0);
    unique case (kind)
      FR_GOOD:
        build_request(exp_addr, exp_func, 16'h0000, $urandom());
      FR_ADDR_BAD:
        build_request(exp_addr ^ 8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
                      16'h0000, $urandom());
      FR_FUNC_BAD:
        build_request(exp_addr, exp_func ^ 8'($urandom_range(1, 255)), 16'h0000, $urandom());
      FR_CRC_BAD:
        build_request(exp_addr, exp_func, 16'($urandom_range(1, 16'hFFFF)), $urandom());
      default: begin
        for (int k = 0; k < FRAME_BYTES; k++) begin
          req_bytes[k] = 8'($urandom_range(0, 255));
        end
      end
    endcase
    if (kind == FR_TIMEOUT) begin
      // partial frame left to age out
      build_request(exp_addr, exp_func, 16'h0000, $urandom());
      n = $urandom_range(1, FRAME_BYTES - 1);
      send_request(n, fin, 1'b1);
      repeat (exp_tmo + 1) send_tick();
    end else begin
      send_request(FRAME_BYTES, fin, 1'b1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Directed: ignored tick, good reply at sensor extremes, sensor failure.
  task automatic test_reply_extremes();
    mrtu_pkg::in_t fin;
    send_tick();  // no partial frame: ignored
    fin = rand_sensor_item(mrtu_pkg::OP_BYTE, 8'h00);
    fin.temperature = -8'sd40;
    fin.humidity    = 7'd100;
    fin.sensor_ok   = 1'b1;
    build_request(exp_addr, exp_func, 16'h0000, 32'hFF00FF00);
    send_request(FRAME_BYTES, fin, 1'b0);
    fin.temperature = 8'sd80;
    fin.humidity    = 7'd0;
    fin.sensor_ok   = 1'b0;
    build_request(exp_addr, exp_func, 16'h0000, 32'h00FF00FF);
    send_request(FRAME_BYTES, fin, 1'b0);
    wait_idle();
  endtask

  // Directed: a byte resets the idle count; ticks past the limit drop the frame.
  task automatic test_idle_timeout();
    write_regs(exp_addr, exp_func, 8'd1);
    send_item(rand_sensor_item(mrtu_pkg::OP_BYTE, 8'hA5));
    send_tick();   // idle 1, at the limit
    send_item(rand_sensor_item(mrtu_pkg::OP_BYTE, 8'h5A));
    send_tick();
    send_tick();   // idle 2: timeout beat
    wait_idle();
  endtask

  // Address, function and CRC failures (each CRC byte once) with random content.
  task automatic test_frame_checks();
    mrtu_pkg::in_t fin;
    fin = rand_sensor_item(mrtu_pkg::OP_BYTE, 8'h00);
    build_request(exp_addr ^ 8'h80, exp_func ^ 8'h01, 16'h0000, $urandom());
    send_request(FRAME_BYTES, fin, 1'b0);   // both wrong: address wins
    build_request(exp_addr, exp_func ^ 8'h40, 16'h0000, $urandom());
    send_request(FRAME_BYTES, fin, 1'b0);
    build_request(exp_addr, exp_func, 16'h0001, $urandom());   // crc low byte off
    send_request(FRAME_BYTES, fin, 1'b0);
    build_request(exp_addr, exp_func, 16'h8000, $urandom());   // crc high byte off
    send_request(FRAME_BYTES, fin, 1'b0);
    wait_idle();
  endtask

  // Register extremes, including a zero timeout.
  task automatic test_config_extremes();
    write_regs(8'd247, 8'd0, 8'd0);
    send_item(rand_sensor_item(mrtu_pkg::OP_BYTE, 8'd247));
    send_tick();   // zero timeout: first tick drops the frame
    repeat (3) send_random_frame();
    wait_idle();
    write_regs(8'd1, 8'd255, 8'd255);
    repeat (3) send_random_frame();
    wait_idle();
  endtask

  // Sink holds off while good requests keep coming, so the engine backs up
  // and stalls its input; then the sender waits for everything to drain.
  task automatic test_backpressure();
    mrtu_pkg::in_t fin;
    hold_off_req = 1'b1;
    steady_send  = 1'b1;
    for (int f = 0; f < 3; f++) begin
      fin = rand_sensor_item(mrtu_pkg::OP_BYTE, 8'h00);
      fin.sensor_ok = 1'b1;
      build_request(exp_addr, exp_func, 16'h0000, $urandom());
      send_request(FRAME_BYTES, fin, 1'b0);
    end
    steady_send = 1'b0;
    wait_idle();
  endtask

  // Mostly well-formed requests under changing random configurations.
  task automatic test_random_traffic();
    int target;
    int phase_end;
    target = active_items + RANDOM_ITEMS;
    while (active_items < target) begin
      wait_idle();
      write_regs(8'($urandom_range(1, 247)),
                 ($urandom_range(0, 1) == 0) ? mrtu_pkg::RST_FUNCTION
                                             : 8'($urandom_range(0, 255)),
                 ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 8)));
      phase_end = active_items + PHASE_ITEMS;
      while (active_items < phase_end && active_items < target) begin
        send_random_frame();
      end
    end
    steady_send = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = mrtu_pkg::CFG_SLAVE_ADDR;
    cfg_data  = 8'h00;

    exp_addr   = mrtu_pkg::RST_SLAVE_ADDR;
    exp_func   = mrtu_pkg::RST_FUNCTION;
    exp_tmo    = mrtu_pkg::RST_TIMEOUT;
    frame_fill = 0;
    idle_ticks = 0;
    for (int k = 0; k < FRAME_BYTES; k++) begin
      frame_buf[k] = 8'h00;
    end

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reply_extremes();
    test_idle_timeout();
    test_frame_checks();
    test_config_extremes();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);   // catch stray beats
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/mrtu_pkg.sv
src/modbus_rtu_slave_frame_engine.sv
src/mrtu_checker.sv
tb/tb.sv
